@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted (active-low reset).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/sfd_pkg.sv @@
// Types, codes and reset values for the frame decoder.
package sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int PHASE_W = 2;
    localparam int INDEX_W = 3;

    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_ESC = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_HUNT  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_FRAME = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ESC   = 2'd2;

    localparam logic [INDEX_W-1:0] REG_BEGIN     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_END       = 3'd1;
    localparam logic [INDEX_W-1:0] REG_ESCAPE    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ESC_BEGIN = 3'd3;
    localparam logic [INDEX_W-1:0] REG_ESC_END   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ESC_ESC   = 3'd5;

    localparam logic [BYTE_W-1:0] RST_BEGIN     = 8'd193;
    localparam logic [BYTE_W-1:0] RST_END       = 8'd192;
    localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd219;
    localparam logic [BYTE_W-1:0] RST_ESC_BEGIN = 8'd222;
    localparam logic [BYTE_W-1:0] RST_ESC_END   = 8'd220;
    localparam logic [BYTE_W-1:0] RST_ESC_ESC   = 8'd221;

    typedef struct packed {
        logic [BYTE_W-1:0] begin_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] escaped_begin_code;
        logic [BYTE_W-1:0] escaped_end_code;
        logic [BYTE_W-1:0] escaped_escape_code;
    } t_cfg;

endpackage

@@ rtl/slip_frame_decoder.sv @@
// SLIP-style frame decoder top level: input register, phase logic, result register.
//
// Takes one received byte per cycle and returns at most one result per byte
// (data, frame end, frame aborted, bad escape). A byte passes from the input
// register through the phase logic into the result register. The sustained
// rate is one byte per cycle, set by the two-bit phase register that each byte
// reads and updates as it leaves the input register. A byte that gives a
// result waits in the input register, and the input stalls, only while the
// result register holds a result that is not taken in the same cycle; bytes
// that give no result never wait.
module slip_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::INDEX_W-1:0]   i_cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfd_pkg::BYTE_W-1:0]    o_data_byte,
    output logic [sfd_pkg::KIND_W-1:0]    o_kind
);

    sfd_pkg::t_cfg w_cfg;

    logic                          r_in_valid;
    logic [sfd_pkg::BYTE_W-1:0]    r_in_byte;
    logic [sfd_pkg::PHASE_W-1:0]   r_phase;
    logic [sfd_pkg::PHASE_W-1:0]   n_phase;
    logic                          r_out_valid;
    logic [sfd_pkg::BYTE_W-1:0]    r_out_data;
    logic [sfd_pkg::KIND_W-1:0]    r_out_kind;

    logic                          w_emit;
    logic [sfd_pkg::BYTE_W-1:0]    w_res_data;
    logic [sfd_pkg::KIND_W-1:0]    w_res_kind;
    logic                          w_out_free;
    logic                          w_advance;
    logic                          w_in_take;

    sfd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    always_comb begin
        n_phase    = r_phase;
        w_emit     = 1'b0;
        w_res_data = '0;
        w_res_kind = sfd_pkg::KIND_DATA;
        case (r_phase)
            sfd_pkg::PHASE_FRAME: begin
                if (r_in_byte == w_cfg.end_code) begin
                    n_phase    = sfd_pkg::PHASE_HUNT;
                    w_emit     = 1'b1;
                    w_res_kind = sfd_pkg::KIND_END;
                end else if (r_in_byte == w_cfg.begin_code) begin
                    w_emit     = 1'b1;
                    w_res_kind = sfd_pkg::KIND_ABORT;
                end else if (r_in_byte == w_cfg.escape_code) begin
                    n_phase = sfd_pkg::PHASE_ESC;
                end else begin
                    w_emit     = 1'b1;
                    w_res_data = r_in_byte;
                end
            end
            sfd_pkg::PHASE_ESC: begin
                w_emit  = 1'b1;
                n_phase = sfd_pkg::PHASE_FRAME;
                if (r_in_byte == w_cfg.escaped_begin_code) begin
                    w_res_data = w_cfg.begin_code;
                end else if (r_in_byte == w_cfg.escaped_end_code) begin
                    w_res_data = w_cfg.end_code;
                end else if (r_in_byte == w_cfg.escaped_escape_code) begin
                    w_res_data = w_cfg.escape_code;
                end else begin
                    n_phase    = sfd_pkg::PHASE_HUNT;
                    w_res_kind = sfd_pkg::KIND_BAD_ESC;
                end
            end
            default: begin
                n_phase = (r_in_byte == w_cfg.begin_code) ? sfd_pkg::PHASE_FRAME
                                                          : sfd_pkg::PHASE_HUNT;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= sfd_pkg::PHASE_HUNT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_phase <= n_phase;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_advance && w_emit) begin
            r_out_data <= w_res_data;
            r_out_kind <= w_res_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_kind      = r_out_kind;

endmodule

@@ rtl/sfd_cfg_regs.sv @@
// Configuration register file holding the token and escape code bytes.
module sfd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfd_pkg::INDEX_W-1:0]      i_cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]       i_cfg_data,
    output sfd_pkg::t_cfg                    o_cfg
);

    sfd_pkg::t_cfg r_cfg;
    sfd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sfd_pkg::REG_BEGIN:     n_cfg.begin_code          = i_cfg_data;
                sfd_pkg::REG_END:       n_cfg.end_code            = i_cfg_data;
                sfd_pkg::REG_ESCAPE:    n_cfg.escape_code         = i_cfg_data;
                sfd_pkg::REG_ESC_BEGIN: n_cfg.escaped_begin_code  = i_cfg_data;
                sfd_pkg::REG_ESC_END:   n_cfg.escaped_end_code    = i_cfg_data;
                sfd_pkg::REG_ESC_ESC:   n_cfg.escaped_escape_code = i_cfg_data;
                default:                n_cfg                     = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.begin_code          <= sfd_pkg::RST_BEGIN;
            r_cfg.end_code            <= sfd_pkg::RST_END;
            r_cfg.escape_code         <= sfd_pkg::RST_ESCAPE;
            r_cfg.escaped_begin_code  <= sfd_pkg::RST_ESC_BEGIN;
            r_cfg.escaped_end_code    <= sfd_pkg::RST_ESC_END;
            r_cfg.escaped_escape_code <= sfd_pkg::RST_ESC_ESC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/sfd_checker.sv @@
// Port-level assertions for the frame decoder, bound to the top level.
`include "assert_macros.svh"

module sfd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [sfd_pkg::BYTE_W-1:0]    o_data_byte,
    input logic [sfd_pkg::KIND_W-1:0]    o_kind
);

    `ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

    `ASSERT_RST(a_ready_when_out_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    `ASSERT_RST(a_ctrl_kind_zero_data, i_clk, i_rst_n, (o_out_valid && (o_kind != sfd_pkg::KIND_DATA)) |-> (o_data_byte == '0), "control result carries data")

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_data_byte) && $stable(o_kind)), "stalled result changed")

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_data_byte (o_data_byte),
    .o_kind      (o_kind)
);
